// ----- hw/rtl/stm_pkg.sv -----
// Shared constants, types and helper functions of the sparse-table range-minimum engine.
package stm_pkg;

  localparam int MAX_LENGTH  = 1024;
  localparam int LEVEL_COUNT = 11;
  localparam int VALUE_WIDTH = 32;

  localparam int POS_W       = $clog2(MAX_LENGTH);
  localparam int LEN_W       = POS_W + 1;
  localparam int LEVEL_W     = $clog2(LEVEL_COUNT);
  localparam int ADDR_W      = LEVEL_W + POS_W;
  localparam int TABLE_DEPTH = LEVEL_COUNT * MAX_LENGTH;
  localparam int TOP_LEVEL   = (LEVEL_COUNT - 1 < POS_W) ? LEVEL_COUNT - 1 : POS_W;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [POS_W-1:0]              pos_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic [LEVEL_W-1:0]            level_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef enum logic {
    FN_LOAD  = 1'b0,
    FN_QUERY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // One access slot of the level table: two reads and one write per cycle.
  typedef struct packed {
    logic   rd_en;
    addr_t  rd_a_addr;
    addr_t  rd_b_addr;
    logic   wr_en;
    addr_t  wr_addr;
    value_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bld_status_t;

  function automatic value_t smin(value_t a, value_t b);
    return (a <= b) ? a : b;
  endfunction

  // Level of a range length: position of its top set bit, capped at the top level.
  function automatic level_t span_level(len_t diff);
    level_t lvl;
    lvl = '0;
    for (int i = 1; i < LEN_W; i++) begin
      if (diff[i] && (i <= TOP_LEVEL)) begin
        lvl = LEVEL_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage

// ----- hw/rtl/stm_intf.sv -----
// Handshake channels of the sparse-table range-minimum engine.
interface stm_cfg_if;
  import stm_pkg::*;
  logic valid;
  logic ready;
  len_t array_length;

  modport source (output valid, output array_length, input ready);
  modport sink   (input valid, input array_length, output ready);
endinterface

interface stm_in_if;
  import stm_pkg::*;
  logic   valid;
  logic   ready;
  func_e  func;
  pos_t   load_position;
  value_t load_value;
  pos_t   range_start;
  len_t   range_end;

  modport source (output valid, output func, output load_position, output load_value,
                  output range_start, output range_end, input ready);
  modport sink   (input valid, input func, input load_position, input load_value,
                  input range_start, input range_end, output ready);
endinterface

interface stm_out_if;
  import stm_pkg::*;
  logic    valid;
  logic    ready;
  value_t  minimum;
  status_e status;

  modport source (output valid, output minimum, output status, input ready);
  modport sink   (input valid, input minimum, input status, output ready);
endinterface

// ----- hw/rtl/stm_mem.sv -----
// Level table storage: one write port, two registered read ports.
module stm_mem (
  input  logic              clk_i,
  input  stm_pkg::mem_req_t req_i,
  output stm_pkg::value_t   rd_a_o,
  output stm_pkg::value_t   rd_b_o
);
  import stm_pkg::*;

  value_t mem_q [TABLE_DEPTH];
  value_t rd_a_q;
  value_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_a_q <= mem_q[req_i.rd_a_addr];
      rd_b_q <= mem_q[req_i.rd_b_addr];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- hw/rtl/stm_builder.sv -----
// Build sequencer: sweeps the table level by level, one entry per cycle, with one idle slot after each level.
module stm_builder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  stm_pkg::value_t      rd_a_i,
  input  stm_pkg::value_t      rd_b_i,
  output stm_pkg::mem_req_t    req_o,
  output stm_pkg::bld_status_t status_o
);
  import stm_pkg::*;

  logic   busy_q, busy_d;
  logic   drain_q, drain_d;
  logic   wr_pend_q, wr_pend_d;
  level_t lvl_q, lvl_d;
  pos_t   idx_q, idx_d;
  addr_t  wr_addr_q, wr_addr_d;

  level_t lvl_below;
  pos_t   half;
  pos_t   idx_last;
  logic   issue;

  assign lvl_below = lvl_q - LEVEL_W'(1);
  assign half      = POS_W'(1) << lvl_below;
  assign idx_last  = POS_W'(LEN_W'(MAX_LENGTH) - (LEN_W'(1) << lvl_q));
  assign issue     = busy_q && !drain_q;

  always_comb begin
    req_o.rd_en     = issue;
    req_o.rd_a_addr = {lvl_below, idx_q};
    req_o.rd_b_addr = {lvl_below, idx_q + half};
    req_o.wr_en     = wr_pend_q;
    req_o.wr_addr   = wr_addr_q;
    req_o.wr_data   = smin(rd_a_i, rd_b_i);
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && drain_q && (lvl_q == LEVEL_W'(TOP_LEVEL));

  always_comb begin
    busy_d    = busy_q;
    drain_d   = drain_q;
    wr_pend_d = 1'b0;
    lvl_d     = lvl_q;
    idx_d     = idx_q;
    wr_addr_d = wr_addr_q;
    if (start_i) begin
      busy_d  = 1'b1;
      drain_d = 1'b0;
      lvl_d   = LEVEL_W'(1);
      idx_d   = '0;
    end else if (issue) begin
      wr_pend_d = 1'b1;
      wr_addr_d = {lvl_q, idx_q};
      if (idx_q == idx_last) begin
        drain_d = 1'b1;
      end else begin
        idx_d = idx_q + POS_W'(1);
      end
    end else if (busy_q) begin
      // one idle slot lets the last write of a level land before the next level reads it
      if (lvl_q == LEVEL_W'(TOP_LEVEL)) begin
        busy_d = 1'b0;
      end else begin
        lvl_d   = lvl_q + LEVEL_W'(1);
        idx_d   = '0;
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      drain_q   <= 1'b0;
      wr_pend_q <= 1'b0;
      lvl_q     <= '0;
      idx_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      drain_q   <= drain_d;
      wr_pend_q <= wr_pend_d;
      lvl_q     <= lvl_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
  end

endmodule

// ----- hw/rtl/sparse_table_range_minimum.sv -----
// Top level of the sparse-table range-minimum engine: item handshake, query path, build control.
// Sparse-table range-minimum engine. A load item writes one signed 32-bit value at a position
// below array_length and gets a registered answer with status ok, or status 2 when the position
// lies past the length. A query item over [range_start, range_end) answers the signed minimum
// of the range: with an up-to-date table it reads two table entries from the level memory in
// the accept cycle and compares them in S_MIN. An empty or reversed range answers status 1, a
// range ending past array_length status 2, both with minimum 0. The first valid query after
// any successful load first rebuilds all levels of the table. The build pass reads two entries
// and writes one per cycle, with one idle slot at the end of each level. After it, S_READ reads
// the two query entries again before the compare. No item is taken meanwhile. Every item
// produces exactly one result. The output register frees the input side: a new item can be
// taken in the cycle the previous result is taken. array_length must be written only while the
// engine is idle; the block does not enforce it. Values above 1024 act as 1024, 0 makes every
// item fail.
module sparse_table_range_minimum (
  input  logic      clk_i,
  input  logic      rst_ni,
  stm_cfg_if.sink   cfg_i,
  stm_in_if.sink    in_i,
  stm_out_if.source out_o
);
  import stm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BUILD = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_MIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       built_q, built_d;
  len_t       cfg_len_q, cfg_len_d;
  logic       out_valid_q, out_valid_d;
  value_t     out_min_q, out_min_d;
  status_e    out_status_q, out_status_d;
  addr_t      qa_addr_q, qa_addr_d;
  addr_t      qb_addr_q, qb_addr_d;

  logic        in_acc;
  len_t        len_eff;
  logic        load_ok;
  logic        q_empty;
  logic        q_range;
  logic        q_go;
  len_t        diff;
  level_t      dep;
  len_t        second_pos;
  addr_t       qa_addr;
  addr_t       qb_addr;
  logic        bld_start;
  mem_req_t    bld_req;
  mem_req_t    top_req;
  mem_req_t    mem_req;
  bld_status_t bld_st;
  value_t      rd_a;
  value_t      rd_b;

  // Configuration is always taken.
  assign cfg_i.ready = 1'b1;
  assign cfg_len_d   = (cfg_i.valid) ? cfg_i.array_length : cfg_len_q;

  // Take an item only when idle and the output slot is free or being drained.
  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;

  // Clamp the length to the table size.
  assign len_eff = (cfg_len_q > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : cfg_len_q;
  assign load_ok = {1'b0, in_i.load_position} < len_eff;
  assign q_empty = {1'b0, in_i.range_start} >= in_i.range_end;
  assign q_range = in_i.range_end > len_eff;
  assign q_go    = in_acc && (in_i.func == FN_QUERY) && !q_empty && !q_range;

  // Level and the two overlapping windows of the query.
  assign diff       = in_i.range_end - {1'b0, in_i.range_start};
  assign dep        = span_level(diff);
  assign second_pos = in_i.range_end - (LEN_W'(1) << dep);
  assign qa_addr    = {dep, in_i.range_start};
  assign qb_addr    = {dep, second_pos[POS_W-1:0]};

  assign bld_start = q_go && !built_q;

  // Query reads go out in the accept cycle when the table is current, else after the build.
  always_comb begin
    top_req.rd_en     = (q_go && built_q) || (state_q == S_READ);
    top_req.rd_a_addr = (state_q == S_READ) ? qa_addr_q : qa_addr;
    top_req.rd_b_addr = (state_q == S_READ) ? qb_addr_q : qb_addr;
    top_req.wr_en     = in_acc && (in_i.func == FN_LOAD) && load_ok;
    top_req.wr_addr   = {LEVEL_W'(0), in_i.load_position};
    top_req.wr_data   = in_i.load_value;
  end

  assign mem_req = bld_st.busy ? bld_req : top_req;

  stm_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  stm_builder u_builder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bld_start),
    .rd_a_i   (rd_a),
    .rd_b_i   (rd_b),
    .req_o    (bld_req),
    .status_o (bld_st)
  );

  always_comb begin
    state_d      = state_q;
    built_d      = built_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_min_d    = out_min_q;
    out_status_d = out_status_q;
    qa_addr_d    = qa_addr_q;
    qb_addr_d    = qb_addr_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          qa_addr_d = qa_addr;
          qb_addr_d = qb_addr;
          if (in_i.func == FN_LOAD) begin
            out_valid_d  = 1'b1;
            out_min_d    = '0;
            out_status_d = load_ok ? ST_OK : ST_RANGE;
            if (load_ok) begin
              built_d = 1'b0;
            end
          end else if (q_empty) begin
            out_valid_d  = 1'b1;
            out_min_d    = '0;
            out_status_d = ST_EMPTY;
          end else if (q_range) begin
            out_valid_d  = 1'b1;
            out_min_d    = '0;
            out_status_d = ST_RANGE;
          end else if (built_q) begin
            state_d = S_MIN;
          end else begin
            state_d = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        if (bld_st.done) begin
          built_d = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_MIN;
      end
      S_MIN: begin
        // The output slot was free at accept and stays free until here.
        out_valid_d  = 1'b1;
        out_min_d    = smin(rd_a, rd_b);
        out_status_d = ST_OK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      built_q     <= 1'b0;
      cfg_len_q   <= LEN_W'(MAX_LENGTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      built_q     <= built_d;
      cfg_len_q   <= cfg_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_min_q    <= out_min_d;
    out_status_q <= out_status_d;
    qa_addr_q    <= qa_addr_d;
    qb_addr_q    <= qb_addr_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.minimum = out_min_q;
  assign out_o.status  = out_status_q;

  // A compare is only ever done on a current table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIN) |-> built_q)
    else $error("range compare on a stale table");

  // The builder owns the memory only while a query waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_st.busy |-> (state_q == S_BUILD))
    else $error("build pass outside the build state");

  // End of the build marks the table current and issues the query reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_st.done |=> (built_q && (state_q == S_READ)))
    else $error("build end not followed by the query read");

  // A successful load invalidates the upper levels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_req.wr_en |=> !built_q)
    else $error("table still marked current after a load");

  // The result slot is never filled while it still holds an untaken item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(out_min_q) && $stable(out_status_q)))
    else $error("pending result overwritten");

endmodule

// ----- tb/sv/sparse_table_range_minimum_test.sv -----
// Self-checking testbench of the sparse-table range-minimum engine.
`timescale 1ns / 100ps

module sparse_table_range_minimum_test;
  import stm_pkg::*;

  // Cycles without a handshake on any channel before the run is declared hung. A rebuild after
  // loads blocks the input for the whole build pass; allow that several times over.
  localparam int unsigned HANG_LIMIT   = 50000;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned REPORT_CAP   = 100;

  typedef struct {
    func_e  func;
    pos_t   load_position;
    value_t load_value;
    pos_t   range_start;
    len_t   range_end;
  } engine_item_t;

  typedef struct {
    value_t  minimum;
    status_e status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stm_cfg_if cfg_if ();
  stm_in_if  in_if ();
  stm_out_if out_if ();

  sparse_table_range_minimum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the engine: level-0 values and the length register. Since every valid query
  // after a successful load rebuilds the levels, the answer always equals the plain
  // minimum over level 0, which a linear scan gives.
  value_t      element_value [MAX_LENGTH];
  len_t        length_setting = len_t'(MAX_LENGTH);
  answer_t     pending_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // Print one line per mismatch (capped so a dead block cannot flood the log) and count it.
  task automatic report_mismatch(string what);
    if (mismatch_count < REPORT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic int unsigned used_length();
    return (length_setting > MAX_LENGTH) ? MAX_LENGTH : int'(length_setting);
  endfunction

  // Apply one accepted item to the shadow state and return the answer it must produce.
  // Status order matters: an empty or reversed range wins over a range past the length.
  function automatic answer_t predict_answer(engine_item_t it);
    answer_t     ans;
    int unsigned used;
    value_t      lowest;
    used = used_length();
    ans.minimum = '0;
    ans.status = ST_OK;
    if (it.func == FN_LOAD) begin
      if (it.load_position >= used) begin
        ans.status = ST_RANGE;
      end else begin
        element_value[it.load_position] = it.load_value;
      end
    end else if (it.range_start >= it.range_end) begin
      ans.status = ST_EMPTY;
    end else if (it.range_end > used) begin
      ans.status = ST_RANGE;
    end else begin
      lowest = element_value[it.range_start];
      for (int p = int'(it.range_start) + 1; p < int'(it.range_end); p++) begin
        if (element_value[p] < lowest) begin
          lowest = element_value[p];
        end
      end
      ans.minimum = lowest;
    end
    return ans;
  endfunction

  // Fields a load does not use are randomized: the engine must ignore them.
  function automatic engine_item_t make_load(pos_t position, value_t value);
    engine_item_t it;
    it.func = FN_LOAD;
    it.load_position = position;
    it.load_value = value;
    it.range_start = pos_t'($urandom);
    it.range_end = len_t'($urandom);
    return it;
  endfunction

  function automatic engine_item_t make_query(pos_t first, len_t stop);
    engine_item_t it;
    it.func = FN_QUERY;
    it.load_position = pos_t'($urandom);
    it.load_value = value_t'($urandom);
    it.range_start = first;
    it.range_end = stop;
    return it;
  endfunction

  // Values lean toward the extremes and toward a narrow band so ties are common.
  function automatic value_t random_value();
    case ($urandom_range(7))
      0:       return value_t'(32'h8000_0000);
      1:       return value_t'(32'h7FFF_FFFF);
      2, 3:    return value_t'(int'($urandom_range(16)) - 8);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Mostly well-formed ranges inside the used length; the rest are empty, reversed or
  // running past the length.
  function automatic engine_item_t random_query();
    int unsigned used;
    int unsigned span;
    int unsigned first;
    int unsigned kind;
    used = used_length();
    kind = $urandom_range(9);
    if (kind == 0) begin
      first = $urandom_range(MAX_LENGTH - 1);
      return make_query(pos_t'(first), len_t'($urandom_range(first)));
    end
    if (kind == 1 || used == 0) begin
      return make_query(pos_t'($urandom_range(MAX_LENGTH - 1)),
                        len_t'($urandom_range(2047, used + 1)));
    end
    case ($urandom_range(3))
      0:       span = 1;
      1:       span = 1 << $urandom_range(10);
      2:       span = $urandom_range(used, 1);
      default: span = $urandom_range((used < 32) ? used : 32, 1);
    endcase
    if (span > used) begin
      span = used;
    end
    first = $urandom_range(used - span);
    return make_query(pos_t'(first), len_t'(first + span));
  endfunction

  // Mostly positions inside the length; some anywhere, which may be past it.
  function automatic engine_item_t random_load();
    int unsigned used;
    used = used_length();
    if (used == 0 || $urandom_range(6) == 0) begin
      return make_load(pos_t'($urandom), random_value());
    end
    return make_load(pos_t'($urandom_range(used - 1)), random_value());
  endfunction

  // Drive one item at the falling edge after a random gap and hold it until accepted.
  // Valid stays high on return, so back-to-back items drop it only during a random gap.
  task automatic send_item(engine_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= it.func;
    in_if.load_position <= it.load_position;
    in_if.load_value    <= it.load_value;
    in_if.range_start   <= it.range_start;
    in_if.range_end     <= it.range_end;
    do @(posedge clk_i); while (!in_if.ready);
    pending_answers = {pending_answers, predict_answer(it)};
  endtask

  // Drop valid and wait until every expected answer has come back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // The length register is written only with the engine idle.
  task automatic write_length(len_t value);
    hold_until_drained();
    @(negedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.array_length <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    length_setting = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned stall_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Extremes of values and positions under the reset length, every status, reversed and
  // empty ranges, windows that overlap and ranges ending past the length. Only loaded
  // positions are ever queried.
  task automatic test_directed_extremes();
    set_idling(0, 0);
    send_item(make_load(pos_t'(0), value_t'(32'h7FFF_FFFF)));
    send_item(make_load(pos_t'(1), value_t'(32'h8000_0000)));
    send_item(make_load(pos_t'(2), value_t'(0)));
    send_item(make_load(pos_t'(3), value_t'(-1)));
    send_item(make_load(pos_t'(4), value_t'(1)));
    send_item(make_load(pos_t'(5), value_t'(5)));
    send_item(make_load(pos_t'(6), value_t'(-5)));
    send_item(make_load(pos_t'(7), value_t'(32'h8000_0000)));
    send_item(make_load(pos_t'(1023), value_t'(32'h5555_AAAA)));
    send_item(make_load(pos_t'(512), value_t'(32'hAAAA_5555)));
    send_item(make_query(pos_t'(0), len_t'(1)));
    send_item(make_query(pos_t'(0), len_t'(8)));
    send_item(make_query(pos_t'(2), len_t'(5)));
    send_item(make_query(pos_t'(4), len_t'(6)));
    send_item(make_query(pos_t'(3), len_t'(8)));
    send_item(make_query(pos_t'(0), len_t'(2)));
    send_item(make_query(pos_t'(1023), len_t'(1024)));
    send_item(make_query(pos_t'(512), len_t'(513)));
    send_item(make_query(pos_t'(5), len_t'(3)));
    send_item(make_query(pos_t'(4), len_t'(4)));
    send_item(make_query(pos_t'(1023), len_t'(0)));
    send_item(make_query(pos_t'(1023), len_t'(2047)));
    send_item(make_query(pos_t'(0), len_t'(1025)));
  endtask

  // Load every position once so any later range covers written entries only.
  task automatic test_fill_table();
    set_idling(18, 18);
    for (int p = 0; p < MAX_LENGTH; p++) begin
      send_item(make_load(pos_t'(p), random_value()));
    end
  endtask

  // Walk the length through its extremes: loads at and just past the edge, a query over
  // the whole used range and one ending a step beyond it.
  task automatic test_length_edges();
    len_t        settings [9];
    int unsigned used;
    settings = '{len_t'(1), len_t'(2), len_t'(0), len_t'(3), len_t'(1023),
                 len_t'(2047), len_t'(1500), len_t'(512), len_t'(1024)};
    set_idling(0, 0);
    foreach (settings[i]) begin
      write_length(settings[i]);
      used = used_length();
      if (used > 0) begin
        send_item(make_load(pos_t'(used - 1), random_value()));
        send_item(make_query(pos_t'(0), len_t'(used)));
        send_item(make_query(pos_t'(used - 1), len_t'(used)));
      end
      if (used < MAX_LENGTH) begin
        send_item(make_load(pos_t'(used), random_value()));
      end
      send_item(make_load(pos_t'(1023), random_value()));
      send_item(make_query(pos_t'((used > 0) ? used - 1 : 0), len_t'(used + 1)));
      send_item(make_query(pos_t'(0), len_t'(0)));
    end
  endtask

  // Bursts of loads followed by bursts of queries, so each burst costs at most one rebuild.
  // Every idling profile gets its share; the length moves now and then, and the sender
  // sometimes holds off until the engine has drained.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned loads;
    int unsigned queries;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(74, 0);
        2:       set_idling(0, 74);
        default: set_idling(18, 18);
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        if ($urandom_range(4) == 0) begin
          case ($urandom_range(9))
            0:       write_length(len_t'(0));
            1:       write_length(len_t'(1));
            2:       write_length(len_t'(2047));
            3:       write_length(len_t'($urandom_range(2047, 1025)));
            4:       write_length(len_t'(MAX_LENGTH));
            5:       write_length(len_t'($urandom_range(16, 1)));
            default: write_length(len_t'($urandom_range(MAX_LENGTH, 1)));
          endcase
        end
        loads = $urandom_range(6, 1);
        queries = $urandom_range(24, 4);
        repeat (loads) send_item(random_load());
        repeat (queries) send_item(random_query());
        sent += loads + queries;
        if ($urandom_range(7) == 0) begin
          hold_until_drained();
        end
      end
    end
  endtask

  // Receiver: decide ready at each falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted answer with the oldest expectation.
  always @(posedge clk_i) begin
    answer_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("answer min=%0d status=%0d with no item pending",
                                  out_if.minimum, out_if.status));
      end else begin
        want = pending_answers.pop_front();
        if (out_if.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_if.status, want.status));
        end
        if (out_if.minimum !== want.minimum) begin
          report_mismatch($sformatf("minimum %0d, expected %0d",
                                    out_if.minimum, want.minimum));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cfg_if.valid        = 1'b0;
    cfg_if.array_length = '0;
    in_if.valid         = 1'b0;
    in_if.func          = FN_LOAD;
    in_if.load_position = '0;
    in_if.load_value    = '0;
    in_if.range_start   = '0;
    in_if.range_end     = '0;
    out_if.ready        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_fill_table();
    test_length_edges();
    test_random_traffic();

    // Drain, then let the engine settle so any stray answer can show.
    hold_until_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
